// File: rtl/btl_pkg.sv
// Shared types and constants for the battery and thermal level limiter.
// Used by btl_regs and battery_thermal_level_limiter_unit; depends on nothing.
`default_nettype none

package btl_pkg;

  // Brightness levels in percent.
  localparam logic [6:0] LEVEL_MAX = 7'd100;
  localparam logic [6:0] LEVEL_MIN = 7'd10;
  localparam logic [6:0] LEVEL_OFF = 7'd0;

  // Minimum-voltage filter.
  localparam logic [3:0] SETTLE_COUNT = 4'd11;
  localparam logic [3:0] RUN_SAT      = 4'd15;
  localparam logic [9:0] VOLT_FULL    = 10'd1023;

  // Temperature conversion.
  localparam logic signed [20:0] ROUND_HALF = 21'sd128;
  localparam logic signed [12:0] KELVIN_OFS = 13'sd273;

  // Register map, word index on the configuration port.
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_VOLT_OFF       = 3'd0,
    REG_VOLT_LOW       = 3'd1,
    REG_VOLT_HALF      = 3'd2,
    REG_TEMP_HIGH      = 3'd3,
    REG_TEMP_LOW       = 3'd4,
    REG_TEMP_OFFSET    = 3'd5,
    REG_TEMP_GAIN      = 3'd6,
    REG_LEVEL_OVERTEMP = 3'd7
  } reg_idx_e;

  // Battery classification codes as they appear on the result.
  typedef enum logic [1:0] {
    BATT_OK    = 2'd0,
    BATT_HALF  = 2'd1,
    BATT_LOW   = 2'd2,
    BATT_EMPTY = 2'd3
  } batt_state_e;

  // Configuration register set.
  typedef struct packed {
    logic        [9:0]  volt_off;
    logic        [9:0]  volt_low;
    logic        [9:0]  volt_half;
    logic signed [10:0] temp_high;
    logic signed [10:0] temp_low;
    logic signed [7:0]  temp_offset;
    logic        [7:0]  temp_gain;
    logic        [6:0]  level_overtemp;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    volt_off:       10'd600,
    volt_low:       10'd700,
    volt_half:      10'd800,
    temp_high:      11'sd70,
    temp_low:       11'sd60,
    temp_offset:    8'sd0,
    temp_gain:      8'd128,
    level_overtemp: 7'd30
  };

endpackage

`default_nettype wire

// File: rtl/battery_thermal_level_limiter_unit.sv
// Battery and thermal brightness limiter, top level.
// Depends on btl_pkg and instantiates btl_regs.
//
// Usage: each input item carries a battery voltage code, a raw temperature
// sensor code, the requested brightness and a restart flag. Each item yields
// exactly one result item: the granted brightness, the battery class, the
// overtemperature flag, the filtered minimum voltage and the temperature.
// Both channels use valid/stall; an item moves on a rising edge with valid
// high and stall low. An accepted item waits in the input register and moves
// into the result register on an edge where that register is empty or its
// item is taken. Throughput is one item per cycle while the receiver does not
// stall; compare, one 12x9 multiply and state update form a single combinational
// pass between the two registers. When the receiver stalls, the result is held
// and one more item is still taken into the input register; the input stalls
// only once both are full. Reset clears both valid bits, sets the held minimum
// to full scale, clears the run counter and the overtemperature flag, and loads
// register defaults. The user must write registers over the APB-style port only
// while no item is in flight; the block does not enforce this.
`default_nettype none

module battery_thermal_level_limiter_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [btl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  // Input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [9:0]                   volt_code_i,
  input  wire logic [9:0]                   temp_code_i,
  input  wire logic [6:0]                   requested_level_i,
  input  wire logic                         restart_i,
  // Result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [6:0]                   granted_level_o,
  output logic      [1:0]                   battery_state_o,
  output logic                              over_temp_o,
  output logic      [9:0]                   min_volt_o,
  output logic signed [10:0]                temp_celsius_o
);

  btl_pkg::cfg_t cfg;

  btl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_take;
  logic s1_take;
  logic fire;

  assign out_take   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_take;
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign s1_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_take) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  logic [9:0] volt_q;
  logic [9:0] raw_q;
  logic [6:0] req_q;
  logic       restart_q;

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      volt_q    <= volt_code_i;
      raw_q     <= temp_code_i;
      req_q     <= requested_level_i;
      restart_q <= restart_i;
    end
  end

  // Filter and hysteresis state.
  logic [9:0] held_q, held_d;
  logic [3:0] run_q, run_d;
  logic       hot_q, hot_d;

  // Minimum-voltage filter: a lower reading is taken only after a settled run.
  logic [9:0] held_base;
  always_comb begin
    held_base = restart_q ? btl_pkg::VOLT_FULL : held_q;
    held_d    = held_base;
    run_d     = run_q;
    if (volt_q < held_base) begin
      if (run_q >= btl_pkg::SETTLE_COUNT) begin
        held_d = volt_q;
      end
      if (run_q < btl_pkg::RUN_SAT) begin
        run_d = run_q + 4'd1;
      end
    end else begin
      run_d = '0;
    end
  end

  // Temperature: ((raw - offset) * gain + 128) >>> 8, minus 273.
  logic signed [11:0] diff;
  logic signed [20:0] prod;
  logic signed [20:0] rounded;
  logic signed [12:0] kelvin;
  logic signed [12:0] celsius_w;
  logic signed [10:0] celsius;

  assign diff      = $signed({2'b00, raw_q})
                   - $signed({{4{cfg.temp_offset[7]}}, cfg.temp_offset});
  assign prod      = diff * $signed({1'b0, cfg.temp_gain});
  assign rounded   = prod + btl_pkg::ROUND_HALF;
  assign kelvin    = rounded[20:8];
  assign celsius_w = kelvin - btl_pkg::KELVIN_OFS;
  assign celsius   = celsius_w[10:0];

  // Overtemperature flag with hysteresis.
  always_comb begin
    hot_d = hot_q;
    if (hot_q) begin
      if (celsius < cfg.temp_low) begin
        hot_d = 1'b0;
      end
    end else if (celsius > cfg.temp_high) begin
      hot_d = 1'b1;
    end
  end

  // Battery class, allowed level, thermal cap and the granted level.
  btl_pkg::batt_state_e state;
  logic [6:0]           allowed_base;
  logic [6:0]           allowed;
  logic [6:0]           granted;

  always_comb begin
    priority if (held_d < cfg.volt_off) begin
      state        = btl_pkg::BATT_EMPTY;
      allowed_base = btl_pkg::LEVEL_OFF;
    end else if (held_d < cfg.volt_low) begin
      state        = btl_pkg::BATT_LOW;
      allowed_base = btl_pkg::LEVEL_MIN;
    end else if (held_d < cfg.volt_half) begin
      state        = btl_pkg::BATT_HALF;
      allowed_base = btl_pkg::LEVEL_MAX;
    end else begin
      state        = btl_pkg::BATT_OK;
      allowed_base = btl_pkg::LEVEL_MAX;
    end
    allowed = (hot_d && (allowed_base > cfg.level_overtemp)) ? cfg.level_overtemp
                                                              : allowed_base;
    granted = (req_q < allowed) ? req_q : allowed;
  end

  // State advances as each item passes into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= btl_pkg::VOLT_FULL;
      run_q  <= '0;
      hot_q  <= 1'b0;
    end else if (fire) begin
      held_q <= held_d;
      run_q  <= run_d;
      hot_q  <= hot_d;
    end
  end

  // Result register.
  logic [6:0]         granted_q;
  logic [1:0]         state_q;
  logic               over_temp_q;
  logic [9:0]         min_volt_q;
  logic signed [10:0] temp_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      granted_q   <= granted;
      state_q     <= state;
      over_temp_q <= hot_d;
      min_volt_q  <= held_d;
      temp_q      <= celsius;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_level_o = granted_q;
  assign battery_state_o = state_q;
  assign over_temp_o     = over_temp_q;
  assign min_volt_o      = min_volt_q;
  assign temp_celsius_o  = temp_q;

`ifndef SYNTHESIS
  // The input side only stalls when both stages hold an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage was free");

  // Without a restart the held minimum never rises.
  a_min_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !restart_q) |=> (held_q <= $past(held_q)))
    else $error("held minimum rose without restart");

  // State changes only when an item passes through.
  a_state_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(hot_q) && $stable(run_q) && $stable(held_q)))
    else $error("filter state changed without an item");

  // An empty battery grants nothing.
  a_empty_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (battery_state_o == btl_pkg::BATT_EMPTY))
      |-> (granted_level_o == btl_pkg::LEVEL_OFF))
    else $error("level granted with empty battery");
`endif

endmodule

`default_nettype wire

// File: rtl/btl_regs.sv
// Configuration register file with an APB-style access port.
// Depends on btl_pkg for the register map, the register struct and reset values.
`default_nettype none

module btl_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [btl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output btl_pkg::cfg_t                     cfg_o
);

  btl_pkg::cfg_t    cfg_q;
  btl_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = btl_pkg::reg_idx_e'(paddr[btl_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= btl_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        btl_pkg::REG_VOLT_OFF:       cfg_q.volt_off       <= pwdata[9:0];
        btl_pkg::REG_VOLT_LOW:       cfg_q.volt_low       <= pwdata[9:0];
        btl_pkg::REG_VOLT_HALF:      cfg_q.volt_half      <= pwdata[9:0];
        btl_pkg::REG_TEMP_HIGH:      cfg_q.temp_high      <= pwdata[10:0];
        btl_pkg::REG_TEMP_LOW:       cfg_q.temp_low       <= pwdata[10:0];
        btl_pkg::REG_TEMP_OFFSET:    cfg_q.temp_offset    <= pwdata[7:0];
        btl_pkg::REG_TEMP_GAIN:      cfg_q.temp_gain      <= pwdata[7:0];
        btl_pkg::REG_LEVEL_OVERTEMP: cfg_q.level_overtemp <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux; signed registers read back sign-extended.
  always_comb begin
    prdata = '0;
    unique case (idx)
      btl_pkg::REG_VOLT_OFF:       prdata = {22'd0, cfg_q.volt_off};
      btl_pkg::REG_VOLT_LOW:       prdata = {22'd0, cfg_q.volt_low};
      btl_pkg::REG_VOLT_HALF:      prdata = {22'd0, cfg_q.volt_half};
      btl_pkg::REG_TEMP_HIGH:      prdata = {{21{cfg_q.temp_high[10]}}, cfg_q.temp_high};
      btl_pkg::REG_TEMP_LOW:       prdata = {{21{cfg_q.temp_low[10]}}, cfg_q.temp_low};
      btl_pkg::REG_TEMP_OFFSET:    prdata = {{24{cfg_q.temp_offset[7]}}, cfg_q.temp_offset};
      btl_pkg::REG_TEMP_GAIN:      prdata = {24'd0, cfg_q.temp_gain};
      btl_pkg::REG_LEVEL_OVERTEMP: prdata = {25'd0, cfg_q.level_overtemp};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: test/btl_checker.sv
// Checker for the battery and thermal level limiter: mirrors register writes,
// predicts one result per accepted item and compares the result channel.
// Depends on btl_pkg for the register map, the battery codes and the limits.
`timescale 1ns / 1ps

module btl_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port, observed only
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [btl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  // Input channel, observed only
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [9:0]                  volt_code_i,
  input  logic [9:0]                  temp_code_i,
  input  logic [6:0]                  requested_level_i,
  input  logic                        restart_i,
  // Result channel, observed only
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [6:0]                  granted_level_i,
  input  logic [1:0]                  battery_state_i,
  input  logic                        over_temp_i,
  input  logic [9:0]                  min_volt_i,
  input  logic signed [10:0]          temp_celsius_i,
  // Status for the testbench top
  output int                          expected_count_o,
  output int                          fail_count_o
);

  // One predicted result item.
  typedef struct {
    logic [6:0]           granted;
    btl_pkg::batt_state_e state;
    logic                 hot;
    logic [9:0]           min_volt;
    logic [10:0]          celsius;
  } limit_t;

  // Mirrored registers and the predicted state of the block.
  btl_pkg::cfg_t cfg;
  logic [9:0]    held_min;
  logic [3:0]    below_run;
  logic          hot;
  limit_t        limit_q[$];
  int            mismatches = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t btl_checker: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Mirror a register write as the block takes it.
  task automatic write_limit_reg(input logic [btl_pkg::PADDR_W-3:0] idx,
                                 input logic [31:0] data);
    case (btl_pkg::reg_idx_e'(idx))
      btl_pkg::REG_VOLT_OFF:       cfg.volt_off = data[9:0];
      btl_pkg::REG_VOLT_LOW:       cfg.volt_low = data[9:0];
      btl_pkg::REG_VOLT_HALF:      cfg.volt_half = data[9:0];
      btl_pkg::REG_TEMP_HIGH:      cfg.temp_high = data[10:0];
      btl_pkg::REG_TEMP_LOW:       cfg.temp_low = data[10:0];
      btl_pkg::REG_TEMP_OFFSET:    cfg.temp_offset = data[7:0];
      btl_pkg::REG_TEMP_GAIN:      cfg.temp_gain = data[7:0];
      btl_pkg::REG_LEVEL_OVERTEMP: cfg.level_overtemp = data[6:0];
      default: ;
    endcase
  endtask

  // Advance the filter and hysteresis state by one measurement and work out
  // the level that the block grants for it.
  function automatic limit_t apply_measurement(input logic [9:0] volt, input logic [9:0] raw,
                                               input logic [6:0] req, input logic restart);
    limit_t     r;
    int         diff;
    int         scaled;
    int         deg;
    logic [6:0] allowed;
    if (restart) held_min = btl_pkg::VOLT_FULL;
    // A lower reading is taken only after a run of earlier lower readings.
    if (volt < held_min) begin
      if (below_run >= btl_pkg::SETTLE_COUNT) held_min = volt;
      if (below_run < btl_pkg::RUN_SAT) below_run++;
    end else begin
      below_run = 0;
    end
    // Temperature with rounding; the arithmetic shift floors negative values.
    diff   = int'(raw) - int'($signed(cfg.temp_offset));
    scaled = diff * int'(cfg.temp_gain) + 128;
    deg    = (scaled >>> 8) - 273;
    if (hot) begin
      if (deg < int'($signed(cfg.temp_low))) hot = 1'b0;
    end else if (deg > int'($signed(cfg.temp_high))) begin
      hot = 1'b1;
    end
    // Thresholds are tested in a fixed order, whether ordered or not.
    if (held_min < cfg.volt_off) begin
      r.state = btl_pkg::BATT_EMPTY;
      allowed = btl_pkg::LEVEL_OFF;
    end else if (held_min < cfg.volt_low) begin
      r.state = btl_pkg::BATT_LOW;
      allowed = btl_pkg::LEVEL_MIN;
    end else if (held_min < cfg.volt_half) begin
      r.state = btl_pkg::BATT_HALF;
      allowed = btl_pkg::LEVEL_MAX;
    end else begin
      r.state = btl_pkg::BATT_OK;
      allowed = btl_pkg::LEVEL_MAX;
    end
    if (hot && allowed > cfg.level_overtemp) allowed = cfg.level_overtemp;
    r.granted  = (req < allowed) ? req : allowed;
    r.hot      = hot;
    r.min_volt = held_min;
    r.celsius  = deg[10:0];
    return r;
  endfunction

  // Results are matched before the item of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    limit_t want;
    if (!rst_ni) begin
      cfg       = btl_pkg::CFG_RESET;
      held_min  = btl_pkg::VOLT_FULL;
      below_run = '0;
      hot       = 1'b0;
      limit_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        write_limit_reg(paddr[btl_pkg::PADDR_W-1:2], pwdata);
      end
      if (out_valid_i && !out_stall_i) begin
        if (limit_q.size() == 0) begin
          report_mismatch("result with no item waiting, granted_level", granted_level_i, -1);
        end else begin
          want = limit_q.pop_front();
          if (granted_level_i !== want.granted) begin
            report_mismatch("granted_level", granted_level_i, want.granted);
          end
          if (battery_state_i !== want.state) begin
            report_mismatch("battery_state", battery_state_i, int'(want.state));
          end
          if (over_temp_i !== want.hot) begin
            report_mismatch("over_temp", over_temp_i, want.hot);
          end
          if (min_volt_i !== want.min_volt) begin
            report_mismatch("min_volt", min_volt_i, want.min_volt);
          end
          if (temp_celsius_i !== want.celsius) begin
            report_mismatch("temp_celsius", int'(temp_celsius_i), int'($signed(want.celsius)));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        limit_q.push_back(apply_measurement(volt_code_i, temp_code_i, requested_level_i,
                                            restart_i));
      end
    end
    expected_count_o <= limit_q.size();
    fail_count_o     <= mismatches;
  end

endmodule

// File: test/tb_top.sv
// Testbench top for battery_thermal_level_limiter_unit: clock, reset, register
// writes, measurement stimulus, result-side stalls and the final verdict.
// Depends on btl_pkg, the block under test and btl_checker.
`timescale 1ns / 1ps

module tb_top;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [btl_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [9:0]                  volt_code_i;
  logic [9:0]                  temp_code_i;
  logic [6:0]                  requested_level_i;
  logic                        restart_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [6:0]                  granted_level_o;
  logic [1:0]                  battery_state_o;
  logic                        over_temp_o;
  logic [9:0]                  min_volt_o;
  logic signed [10:0]          temp_celsius_o;
  int                          expected_count;
  int                          fail_count;

  // Requests for a long receiver hold-off, served by the receiver process.
  int hold_requests = 0;
  // Slowly discharging battery and drifting sensor for the random items.
  int volt_base;
  int raw_walk;

  battery_thermal_level_limiter_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .volt_code_i       (volt_code_i),
    .temp_code_i       (temp_code_i),
    .requested_level_i (requested_level_i),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_level_o   (granted_level_o),
    .battery_state_o   (battery_state_o),
    .over_temp_o       (over_temp_o),
    .min_volt_o        (min_volt_o),
    .temp_celsius_o    (temp_celsius_o)
  );

  btl_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .volt_code_i       (volt_code_i),
    .temp_code_i       (temp_code_i),
    .requested_level_i (requested_level_i),
    .restart_i         (restart_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_level_i   (granted_level_o),
    .battery_state_i   (battery_state_o),
    .over_temp_i       (over_temp_o),
    .min_volt_i        (min_volt_o),
    .temp_celsius_i    (temp_celsius_o),
    .expected_count_o  (expected_count),
    .fail_count_o      (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard limit on the run time.
  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input btl_pkg::reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_limits(input btl_pkg::cfg_t c);
    apb_write(btl_pkg::REG_VOLT_OFF, 32'(c.volt_off));
    apb_write(btl_pkg::REG_VOLT_LOW, 32'(c.volt_low));
    apb_write(btl_pkg::REG_VOLT_HALF, 32'(c.volt_half));
    apb_write(btl_pkg::REG_TEMP_HIGH, 32'(c.temp_high));
    apb_write(btl_pkg::REG_TEMP_LOW, 32'(c.temp_low));
    apb_write(btl_pkg::REG_TEMP_OFFSET, 32'(c.temp_offset));
    apb_write(btl_pkg::REG_TEMP_GAIN, 32'(c.temp_gain));
    apb_write(btl_pkg::REG_LEVEL_OVERTEMP, 32'(c.level_overtemp));
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_measurement(input logic [9:0] volt, input logic [9:0] raw,
                                  input logic [6:0] req, input logic restart);
    in_valid_i        <= 1'b1;
    volt_code_i       <= volt;
    temp_code_i       <= raw;
    requested_level_i <= req;
    restart_i         <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_count != 0) @(posedge clk_i);
  endtask

  // Mostly ordered thresholds, hysteresis around everyday temperatures.
  function automatic btl_pkg::cfg_t random_limits();
    btl_pkg::cfg_t c;
    int            a;
    int            b;
    int            d;
    int            s;
    int            tl;
    a = $urandom_range(0, 1023);
    b = $urandom_range(0, 1023);
    d = $urandom_range(0, 1023);
    if ($urandom_range(0, 3) != 0) begin
      if (a > b) begin s = a; a = b; b = s; end
      if (b > d) begin s = b; b = d; d = s; end
      if (a > b) begin s = a; a = b; b = s; end
    end
    tl = int'($urandom_range(0, 300)) - 100;
    c.volt_off       = a[9:0];
    c.volt_low       = b[9:0];
    c.volt_half      = d[9:0];
    c.temp_low       = 11'(tl);
    c.temp_high      = 11'(tl + int'($urandom_range(0, 30)) - 5);
    c.temp_offset    = 8'($urandom_range(0, 255));
    c.temp_gain      = 8'($urandom_range(0, 255));
    c.level_overtemp = 7'($urandom_range(0, 127));
    return c;
  endfunction

  // Extremes of every field, the settling run, restart without clearing the
  // run, hysteresis set, hold and clear, and requests above range.
  task automatic directed_items();
    int k;
    send_measurement(10'd1023, 10'd0, 7'd0, 1'b0);
    send_measurement(10'd0, 10'd1023, 7'd100, 1'b0);
    send_measurement(10'd1023, 10'd680, 7'd127, 1'b0);
    send_measurement(10'd1023, 10'd600, 7'd127, 1'b1);
    // Thirteen lower readings: the twelfth is the first one taken.
    for (k = 0; k < 13; k++) send_measurement(10'd650, 10'd400, 7'd55, 1'b0);
    send_measurement(10'd550, 10'd400, 7'd100, 1'b0);
    // Restart keeps the run, so this reading is taken at once and lengthens it.
    send_measurement(10'd1000, 10'd400, 7'd100, 1'b1);
    send_measurement(10'd1023, 10'd1023, 7'd127, 1'b0);
    send_measurement(10'd0, 10'd0, 7'd0, 1'b1);
    send_measurement(10'd750, 10'd500, 7'd100, 1'b0);
  endtask

  task automatic random_measurement();
    int           volt;
    logic [6:0]   req;
    logic         restart;
    restart = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      restart   = 1'b1;
      volt_base = $urandom_range(300, 1023);
    end
    volt_base = volt_base - int'($urandom_range(0, 2));
    if (volt_base < 0) volt_base = 0;
    volt = volt_base - int'($urandom_range(0, 6));
    if (volt < 0) volt = 0;
    if ($urandom_range(0, 15) == 0) volt = $urandom_range(0, 1023);
    raw_walk = raw_walk + int'($urandom_range(0, 40)) - 20;
    if (raw_walk < 0) raw_walk = 0;
    if (raw_walk > 1023) raw_walk = 1023;
    if ($urandom_range(0, 15) == 0) raw_walk = $urandom_range(0, 1023);
    if ($urandom_range(0, 7) == 0) req = 7'($urandom_range(0, 127));
    else req = 7'($urandom_range(0, 100));
    send_measurement(volt[9:0], raw_walk[9:0], req, restart);
  endtask

  // Bursts of items with random gaps, now and then a full drain.
  task automatic random_items(input int count);
    int sent;
    int burst;
    int gap;
    int k;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && sent < count; k++) begin
        random_measurement();
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic run_phase(input btl_pkg::cfg_t c, input int count, input bit long_hold);
    drain_results();
    repeat (3) @(posedge clk_i);
    write_limits(c);
    if (long_hold) hold_requests <= hold_requests + 1;
    random_items(count);
  endtask

  // Receiver: segments of differing stall density, and long hold-offs on request.
  initial begin
    int served;
    int span;
    int mode;
    int k;
    served = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (served != hold_requests) begin
        served++;
        span = $urandom_range(150, 300);
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 60);
        for (k = 0; k < span; k++) begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            2:       out_stall_i <= ($urandom_range(0, 1) == 0);
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    btl_pkg::cfg_t lo_limits;
    btl_pkg::cfg_t hi_limits;
    btl_pkg::cfg_t mixed_limits;
    int            k;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid_i        = 1'b0;
    volt_code_i       = '0;
    temp_code_i       = '0;
    requested_level_i = '0;
    restart_i         = 1'b0;
    out_stall_i       = 1'b0;
    volt_base         = 1023;
    raw_walk          = 700;
    lo_limits = '{volt_off: 10'd0, volt_low: 10'd0, volt_half: 10'd0,
                  temp_high: -11'sd273, temp_low: -11'sd273, temp_offset: -8'sd128,
                  temp_gain: 8'd0, level_overtemp: 7'd0};
    hi_limits = '{volt_off: 10'd1023, volt_low: 10'd1023, volt_half: 10'd1023,
                  temp_high: 11'sd1023, temp_low: 11'sd1023, temp_offset: 8'sd127,
                  temp_gain: 8'd255, level_overtemp: 7'd127};
    mixed_limits = '{volt_off: 10'd900, volt_low: 10'd300, volt_half: 10'd500,
                     temp_high: 11'sd20, temp_low: 11'sd40, temp_offset: -8'sd128,
                     temp_gain: 8'd255, level_overtemp: 7'd127};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limits(btl_pkg::CFG_RESET);
    directed_items();
    run_phase(lo_limits, 210, 1'b0);
    run_phase(hi_limits, 210, 1'b1);
    run_phase(mixed_limits, 210, 1'b0);
    for (k = 0; k < 3; k++) run_phase(random_limits(), 230, k == 1);

    drain_results();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && expected_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/btl_pkg.sv
rtl/btl_regs.sv
rtl/battery_thermal_level_limiter_unit.sv
test/btl_checker.sv
test/tb_top.sv
